>>> src/aarm_pkg.sv
package aarm_pkg;

  localparam int AXIS_WIDTH_DEF  = 16;
  localparam int PHASE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;

  localparam int OUT_W        = 16;
  localparam int ISQRT_STEPS  = 32;
  localparam int DIV_STEPS    = 31;
  localparam int TAYLOR_TERMS = 13;

  localparam int LAT_AXIS  = 5 + ISQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int LAT_SC    = 3 + 3 * TAYLOR_TERMS + 1;
  localparam int LAT_MAT   = 6;
  localparam int LAT_TOTAL = LAT_AXIS + LAT_MAT;

  localparam logic [33:0] PI_Q32 = 34'h3243F6A89;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [32:0] sc_t;

  function automatic logic [4:0] norm_shift(logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return (p >= 5'd30) ? 5'd0 : 5'(5'd30 - p);
  endfunction

  function automatic logic signed [35:0] rnd_q30(logic signed [66:0] v);
    logic [66:0] mag;
    logic [66:0] r;
    mag = v[66] ? 67'(-v) : 67'(v);
    r = (mag + (67'd1 << 29)) >> 30;
    return v[66] ? -$signed(36'(r)) : $signed(36'(r));
  endfunction

endpackage

>>> src/aarm_delay.sv
module aarm_delay #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 27
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];
endmodule

>>> src/aarm_axis_norm.sv
module aarm_axis_norm #(
  parameter int AXIS_WIDTH = aarm_pkg::AXIS_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [AXIS_WIDTH-1:0] axis_x,
  input  logic signed [AXIS_WIDTH-1:0] axis_y,
  input  logic signed [AXIS_WIDTH-1:0] axis_z,
  output logic                         out_valid,
  output aarm_pkg::q30_t               u_x,
  output aarm_pkg::q30_t               u_y,
  output aarm_pkg::q30_t               u_z,
  output logic                         zero
);
  import aarm_pkg::*;

  typedef struct packed {
    logic            zero;
    logic [2:0]      neg;
    logic [2:0][31:0] mag;
  } side_t;

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [31:0]      norm;
    logic [2:0][63:0] rem;
    logic [2:0][30:0] quo;
  } div_t;

  logic signed [32:0] ext [3];
  logic va, vb, vc, vd, ve;
  side_t sa, sb, sc, sd, se;
  logic [4:0] shb;
  logic [31:0] mx;
  logic [2:0][63:0] sqd;
  logic [63:0] n2;

  always_comb begin
    ext[0] = 33'(axis_x);
    ext[1] = 33'(axis_y);
    ext[2] = 33'(axis_z);
    mx = sa.mag[0];
    if (sa.mag[1] > mx) mx = sa.mag[1];
    if (sa.mag[2] > mx) mx = sa.mag[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
    for (int i = 0; i < 3; i++) begin
      sa.neg[i] <= ext[i][32];
      sa.mag[i] <= ext[i][32] ? 32'(-ext[i]) : 32'(ext[i]);
    end
    sa.zero <= (ext[0] == '0) && (ext[1] == '0) && (ext[2] == '0);
    sb <= sa;
    shb <= norm_shift(mx);
    sc.zero <= sb.zero;
    sc.neg  <= sb.neg;
    for (int i = 0; i < 3; i++) begin
      sc.mag[i] <= sb.mag[i] << shb;
    end
    sd <= sc;
    for (int i = 0; i < 3; i++) begin
      sqd[i] <= 64'(sc.mag[i]) * 64'(sc.mag[i]);
    end
    se <= sd;
    n2 <= sqd[0] + sqd[1] + sqd[2];
  end

  logic        qv [ISQRT_STEPS+1];
  logic [63:0] qn [ISQRT_STEPS+1];
  logic [63:0] qr [ISQRT_STEPS+1];
  side_t       qs [ISQRT_STEPS+1];

  always_comb begin
    qv[0] = ve;
    qn[0] = n2;
    qr[0] = '0;
    qs[0] = se;
  end

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    always_ff @(posedge clk) begin
      if (rst) qv[k+1] <= 1'b0;
      else qv[k+1] <= qv[k];
      qs[k+1] <= qs[k];
      if (qn[k] >= qr[k] + BIT) begin
        qn[k+1] <= qn[k] - (qr[k] + BIT);
        qr[k+1] <= (qr[k] >> 1) + BIT;
      end else begin
        qn[k+1] <= qn[k];
        qr[k+1] <= qr[k] >> 1;
      end
    end
  end

  logic [31:0] norm;
  logic dv [DIV_STEPS+1];
  div_t dd [DIV_STEPS+1];

  assign norm = qr[ISQRT_STEPS][31:0];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else dv[0] <= qv[ISQRT_STEPS];
    dd[0].zero <= qs[ISQRT_STEPS].zero;
    dd[0].neg  <= qs[ISQRT_STEPS].neg;
    dd[0].norm <= norm;
    dd[0].quo  <= '0;
    for (int i = 0; i < 3; i++) begin
      dd[0].rem[i] <= (64'(qs[ISQRT_STEPS].mag[i]) << 30) + 64'(norm >> 1);
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [63:0] sub;
    div_t step_next;
    assign sub = 64'(dd[j].norm) << (DIV_STEPS - 1 - j);
    always_comb begin
      step_next = dd[j];
      for (int i = 0; i < 3; i++) begin
        if (dd[j].rem[i] >= sub) begin
          step_next.rem[i] = dd[j].rem[i] - sub;
          step_next.quo[i][DIV_STEPS-1-j] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else dv[j+1] <= dv[j];
      dd[j+1] <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= dv[DIV_STEPS];
    zero <= dd[DIV_STEPS].zero;
    u_x <= dd[DIV_STEPS].neg[0] ? -$signed(32'(dd[DIV_STEPS].quo[0]))
                                 : $signed(32'(dd[DIV_STEPS].quo[0]));
    u_y <= dd[DIV_STEPS].neg[1] ? -$signed(32'(dd[DIV_STEPS].quo[1]))
                                 : $signed(32'(dd[DIV_STEPS].quo[1]));
    u_z <= dd[DIV_STEPS].neg[2] ? -$signed(32'(dd[DIV_STEPS].quo[2]))
                                 : $signed(32'(dd[DIV_STEPS].quo[2]));
  end
endmodule

>>> src/aarm_sincos.sv
module aarm_sincos #(
  parameter int PHASE_WIDTH = aarm_pkg::PHASE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic [PHASE_WIDTH-1:0] turn_phase,
  output aarm_pkg::sc_t          sin_q30,
  output aarm_pkg::sc_t          cos_q30
);
  import aarm_pkg::*;

  typedef struct packed {
    logic [1:0] quad;
    logic       fold;
    logic [30:0] theta;
  } ang_t;

  logic [31:0] p32;
  logic [29:0] r0;
  logic [29:0] rf;
  logic [1:0]  quad0, quad1, quad2;
  logic        fold0, fold1, fold2;
  logic [63:0] prod;
  logic [30:0] theta2;

  always_comb begin
    p32 = 32'(turn_phase) << (32 - PHASE_WIDTH);
    r0  = p32[29:0];
  end

  always_ff @(posedge clk) begin
    quad0 <= p32[31:30];
    fold0 <= r0[29];
    rf    <= r0[29] ? 30'((31'd1 << 30) - 31'(r0)) : r0;
    quad1 <= quad0;
    fold1 <= fold0;
    prod  <= 64'(rf) * 64'(PI_Q32);
    quad2 <= quad1;
    fold2 <= fold1;
    theta2 <= 31'((prod + (64'd1 << 32)) >> 33);
  end

  logic [30:0] tt [TAYLOR_TERMS+1];
  sc_t         ts [TAYLOR_TERMS+1];
  sc_t         tc [TAYLOR_TERMS+1];
  ang_t        ta [TAYLOR_TERMS+1];

  always_comb begin
    tt[0] = 31'd1 << 30;
    ts[0] = '0;
    tc[0] = 33'sd1 <<< 30;
    ta[0].quad  = quad2;
    ta[0].fold  = fold2;
    ta[0].theta = theta2;
  end

  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
    localparam int K = k;
    localparam int KM = K % 4;
    localparam logic [31:0] M = 32'((64'd1 << 31) / K);
    logic [61:0] p1;
    sc_t s1, c1, s2, c2;
    ang_t a1, a2;
    logic [31:0] x2;
    logic [63:0] y2;
    logic [31:0] qe, rm, q;

    always_comb begin
      qe = 32'(y2 >> 31);
      rm = x2 - 32'(qe * 32'(K));
      q  = (rm >= 32'(K)) ? qe + 32'd1 : qe;
    end

    always_ff @(posedge clk) begin
      p1 <= 62'(tt[k-1]) * 62'(ta[k-1].theta);
      s1 <= ts[k-1];
      c1 <= tc[k-1];
      a1 <= ta[k-1];
      x2 <= 32'((p1 + (62'd1 << 29)) >> 30) + 32'(K >> 1);
      y2 <= 64'(32'((p1 + (62'd1 << 29)) >> 30) + 32'(K >> 1)) * 64'(M);
      s2 <= s1;
      c2 <= c1;
      a2 <= a1;
      tt[k] <= 31'(q);
      ta[k] <= a2;
      ts[k] <= (KM == 1) ? s2 + $signed(33'(q)) :
               (KM == 3) ? s2 - $signed(33'(q)) : s2;
      tc[k] <= (KM == 2) ? c2 - $signed(33'(q)) :
               (KM == 0) ? c2 + $signed(33'(q)) : c2;
    end
  end

  sc_t ss, cc;

  always_comb begin
    ss = ta[TAYLOR_TERMS].fold ? tc[TAYLOR_TERMS] : ts[TAYLOR_TERMS];
    cc = ta[TAYLOR_TERMS].fold ? ts[TAYLOR_TERMS] : tc[TAYLOR_TERMS];
  end

  always_ff @(posedge clk) begin
    case (ta[TAYLOR_TERMS].quad)
      2'd0: begin
        sin_q30 <= ss;
        cos_q30 <= cc;
      end
      2'd1: begin
        sin_q30 <= cc;
        cos_q30 <= -ss;
      end
      2'd2: begin
        sin_q30 <= -ss;
        cos_q30 <= -cc;
      end
      default: begin
        sin_q30 <= -cc;
        cos_q30 <= ss;
      end
    endcase
  end
endmodule

>>> src/aarm_matrix.sv
module aarm_matrix #(
  parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        zero_in,
  input  aarm_pkg::q30_t              u_x,
  input  aarm_pkg::q30_t              u_y,
  input  aarm_pkg::q30_t              u_z,
  input  aarm_pkg::sc_t               sin_q30,
  input  aarm_pkg::sc_t               cos_q30,
  output logic                        out_valid,
  output logic                        zero_out,
  output logic [8:0][aarm_pkg::OUT_W-1:0] ent
);
  import aarm_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam logic [37:0] HALF = (SH == 0) ? 38'd0 : (38'd1 << ((SH == 0) ? 0 : SH - 1));
  localparam logic signed [37:0] LIM = 38'sd1 <<< FRAC_BITS;

  logic v0, v1, v2, v3, v4;
  logic z0, z1, z2, z3, z4;
  q30_t u [3];
  logic signed [63:0] uu0 [6];
  logic signed [64:0] su0 [3];
  logic signed [33:0] omc0, omc1;
  sc_t c0, c1, c2, c3;
  logic signed [35:0] uu1 [6];
  logic signed [35:0] su1 [3], su2 [3], su3 [3];
  logic signed [66:0] mm2 [6];
  logic signed [35:0] mr3 [6];
  logic signed [37:0] m4 [9];

  assign u[0] = u_x;
  assign u[1] = u_y;
  assign u[2] = u_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
    z0 <= zero_in;
    z1 <= z0;
    z2 <= z1;
    z3 <= z2;
    z4 <= z3;
    zero_out <= z4;

    uu0[0] <= 64'(u[0]) * 64'(u[0]);
    uu0[1] <= 64'(u[0]) * 64'(u[1]);
    uu0[2] <= 64'(u[0]) * 64'(u[2]);
    uu0[3] <= 64'(u[1]) * 64'(u[1]);
    uu0[4] <= 64'(u[1]) * 64'(u[2]);
    uu0[5] <= 64'(u[2]) * 64'(u[2]);
    for (int i = 0; i < 3; i++) begin
      su0[i] <= 65'(sin_q30) * 65'(u[i]);
    end
    omc0 <= (34'sd1 <<< 30) - 34'(cos_q30);
    c0 <= cos_q30;

    for (int i = 0; i < 6; i++) begin
      uu1[i] <= rnd_q30(67'(uu0[i]));
    end
    for (int i = 0; i < 3; i++) begin
      su1[i] <= rnd_q30(67'(su0[i]));
    end
    omc1 <= omc0;
    c1 <= c0;

    for (int i = 0; i < 6; i++) begin
      mm2[i] <= 67'(omc1) * 67'(uu1[i]);
    end
    su2 <= su1;
    c2 <= c1;

    for (int i = 0; i < 6; i++) begin
      mr3[i] <= rnd_q30(mm2[i]);
    end
    su3 <= su2;
    c3 <= c2;

    m4[0] <= 38'(mr3[0]) + 38'(c3);
    m4[1] <= 38'(mr3[1]) - 38'(su3[2]);
    m4[2] <= 38'(mr3[2]) + 38'(su3[1]);
    m4[3] <= 38'(mr3[1]) + 38'(su3[2]);
    m4[4] <= 38'(mr3[3]) + 38'(c3);
    m4[5] <= 38'(mr3[4]) - 38'(su3[0]);
    m4[6] <= 38'(mr3[2]) - 38'(su3[1]);
    m4[7] <= 38'(mr3[4]) + 38'(su3[0]);
    m4[8] <= 38'(mr3[5]) + 38'(c3);
  end

  logic [37:0] mag5 [9];
  logic [37:0] rq5 [9];
  logic signed [37:0] v5 [9];
  logic [8:0][OUT_W-1:0] ent_next;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mag5[i] = m4[i][37] ? 38'(-m4[i]) : 38'(m4[i]);
      rq5[i] = (mag5[i] + HALF) >> SH;
      v5[i] = m4[i][37] ? -$signed(rq5[i]) : $signed(rq5[i]);
      if (v5[i] > LIM) v5[i] = LIM;
      if (v5[i] < -LIM) v5[i] = -LIM;
      if (z4) v5[i] = (i % 4 == 0) ? LIM : '0;
      ent_next[i] = v5[i][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end
endmodule

>>> src/axis_angle_rotation_matrix.sv
// Axis-angle to 3x3 rotation matrix generator (Rodrigues form).
// Input: drive axis_x/y/z and turn_phase with start high; a transfer
// happens at each clock edge with start high and busy low. busy stays
// low, so one item can be taken every cycle.
// Output: done is high for one cycle per result with r00..r22 (row-major,
// signed with FRAC_BITS fraction bits, clamped to +/-1.0) and zero_axis.
// A zero axis gives the identity matrix with zero_axis high.
// The axis path sets the time from accepting a transfer to done: its
// magnitude, alignment and sum-of-squares stages, 32 one-bit square-root
// stages, a divider setup stage, 31 one-bit division stages and a sign
// stage, then the matrix products, rounding and clamping. The sine/cosine
// path (a product, a reciprocal multiply and a correction per Taylor term)
// is delayed to meet it. Throughput is one item per cycle.
// Reset clears all valid bits; items in flight are dropped and no done
// follows. The receiver cannot stall: each result is on the ports for
// one cycle only.
module axis_angle_rotation_matrix #(
  parameter int AXIS_WIDTH  = aarm_pkg::AXIS_WIDTH_DEF,
  parameter int PHASE_WIDTH = aarm_pkg::PHASE_WIDTH_DEF,
  parameter int FRAC_BITS   = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [AXIS_WIDTH-1:0] axis_x,
  input  logic signed [AXIS_WIDTH-1:0] axis_y,
  input  logic signed [AXIS_WIDTH-1:0] axis_z,
  input  logic [PHASE_WIDTH-1:0]       turn_phase,
  output logic                         done,
  output logic signed [15:0]           r00,
  output logic signed [15:0]           r01,
  output logic signed [15:0]           r02,
  output logic signed [15:0]           r10,
  output logic signed [15:0]           r11,
  output logic signed [15:0]           r12,
  output logic signed [15:0]           r20,
  output logic signed [15:0]           r21,
  output logic signed [15:0]           r22,
  output logic                         zero_axis
);
  import aarm_pkg::*;

  localparam int OUTLIM = 1 << FRAC_BITS;

  logic accept;
  logic ax_valid, ax_zero;
  q30_t ux, uy, uz;
  sc_t s_raw, c_raw, s_al, c_al;
  logic [8:0][OUT_W-1:0] ent;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  aarm_axis_norm #(.AXIS_WIDTH(AXIS_WIDTH)) u_axis (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .axis_x   (axis_x),
    .axis_y   (axis_y),
    .axis_z   (axis_z),
    .out_valid(ax_valid),
    .u_x      (ux),
    .u_y      (uy),
    .u_z      (uz),
    .zero     (ax_zero)
  );

  aarm_sincos #(.PHASE_WIDTH(PHASE_WIDTH)) u_sincos (
    .clk       (clk),
    .turn_phase(turn_phase),
    .sin_q30   (s_raw),
    .cos_q30   (c_raw)
  );

  aarm_delay #(.WIDTH(66), .DEPTH(LAT_AXIS - LAT_SC)) u_align (
    .clk (clk),
    .din ({s_raw, c_raw}),
    .dout({s_al, c_al})
  );

  aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ax_valid),
    .zero_in  (ax_zero),
    .u_x      (ux),
    .u_y      (uy),
    .u_z      (uz),
    .sin_q30  (s_al),
    .cos_q30  (c_al),
    .out_valid(done),
    .zero_out (zero_axis),
    .ent      (ent)
  );

  assign r00 = ent[0];
  assign r01 = ent[1];
  assign r02 = ent[2];
  assign r10 = ent[3];
  assign r11 = ent[4];
  assign r12 = ent[5];
  assign r20 = ent[6];
  assign r21 = ent[7];
  assign r22 = ent[8];

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT_TOTAL))
    else $error("done without matching transfer");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> zero_axis == $past(axis_x == '0 && axis_y == '0 && axis_z == '0, LAT_TOTAL))
    else $error("zero_axis does not match accepted axis");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    done && zero_axis |-> r01 == '0 && r12 == '0 && r20 == '0)
    else $error("zero axis gave non-identity matrix");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> FRAC_BITS > 14 || (int'(r11) <= OUTLIM && int'(r11) >= -OUTLIM))
    else $error("diagonal entry outside clamp range");
endmodule

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aarm_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, az;
    logic [15:0]        ph;
  } rot_req_t;

  typedef struct {
    logic [15:0] m [9];
    logic        za;
  } rot_mat_t;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE_Q30 = longint'(1) << 30;
  localparam int IDLE_LIMIT = 4 * LAT_TOTAL + 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic [15:0] turn_phase = '0;
  logic done;
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic zero_axis;

  rot_req_t pending_reqs[$];
  rot_mat_t expected_mats[$];
  int mismatches = 0;
  int matrices_seen = 0;
  int zero_axis_seen = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit quiet_tail = 1'b0;
  bit driving_done = 1'b0;

  axis_angle_rotation_matrix dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .turn_phase(turn_phase),
    .done(done), .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11),
    .r12(r12), .r20(r20), .r21(r21), .r22(r22), .zero_axis(zero_axis)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v < 0) return -((-v + half) >>> sh);
    return (v + half) >>> sh;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic void phase_sin_cos(input logic [15:0] ph, output longint s,
                                        output longint c);
    logic [31:0] p32;
    longint unsigned r, theta, t;
    longint ts, tc, ss, cc;
    bit fold;
    p32 = {ph, 16'h0};
    r = p32[29:0];
    fold = r >= (longint'(1) << 29);
    if (fold) r = (longint'(1) << 30) - r;
    theta = (r * longint'(PI_Q32) + (longint'(1) << 32)) >> 33;
    t = ONE_Q30;
    ts = 0;
    tc = ONE_Q30;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      t = (t * theta + (longint'(1) << 29)) >> 30;
      t = (t + (k >> 1)) / k;
      case (k % 4)
        1: ts += t;
        2: tc -= t;
        3: ts -= t;
        default: tc += t;
      endcase
    end
    ss = fold ? tc : ts;
    cc = fold ? ts : tc;
    case (p32[31:30])
      2'd0: begin s = ss; c = cc; end
      2'd1: begin s = cc; c = -ss; end
      2'd2: begin s = -ss; c = -cc; end
      default: begin s = -cc; c = ss; end
    endcase
  endfunction

  function automatic logic [15:0] clamp_entry(longint q30);
    longint v, lim;
    v = round_shift(q30, 30 - FB);
    lim = longint'(1) << FB;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function automatic rot_mat_t rodrigues_matrix(rot_req_t q);
    rot_mat_t e;
    longint a[3], u[3], m[9];
    longint unsigned mag[3], mx, norm;
    longint s, c, omc;
    a[0] = q.ax;
    a[1] = q.ay;
    a[2] = q.az;
    for (int i = 0; i < 3; i++) mag[i] = (a[i] < 0) ? -a[i] : a[i];
    e.za = 1'b0;
    if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
      for (int i = 0; i < 9; i++) e.m[i] = (i % 4 == 0) ? 16'(longint'(1) << FB) : 16'h0;
      e.za = 1'b1;
      return e;
    end
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    while (mx < ONE_Q30) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    norm = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'(((mag[i] << 30) + (norm >> 1)) / norm);
      if (a[i] < 0) u[i] = -u[i];
    end
    phase_sin_cos(q.ph, s, c);
    omc = ONE_Q30 - c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i * 3 + j] = qmul(omc, qmul(u[i], u[j]));
    m[0] += c;
    m[4] += c;
    m[8] += c;
    m[1] -= qmul(s, u[2]);
    m[2] += qmul(s, u[1]);
    m[3] += qmul(s, u[2]);
    m[5] -= qmul(s, u[0]);
    m[6] -= qmul(s, u[1]);
    m[7] += qmul(s, u[0]);
    for (int i = 0; i < 9; i++) e.m[i] = clamp_entry(m[i]);
    return e;
  endfunction

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 7)) - 16'sd3;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'($urandom_range(0, 255)) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_req(logic signed [15:0] x, y, z, logic [15:0] p);
    rot_req_t q;
    q.ax = x;
    q.ay = y;
    q.az = z;
    q.ph = p;
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  initial begin
    logic [15:0] pts[8];
    pts = '{16'h0000, 16'h2000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h1fff, 16'h0001};
    queue_req(0, 0, 0, 16'h1234);
    queue_req(0, 0, 0, 16'hffff);
    queue_req(16'sh7fff, 0, 0, 16'h4000);
    queue_req(16'sh8000, 0, 0, 16'h4000);
    queue_req(0, 16'sh7fff, 0, 16'h8000);
    queue_req(0, 0, 16'sh8000, 16'hc000);
    queue_req(16'sh8000, 16'sh8000, 16'sh8000, 16'h2000);
    queue_req(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
    queue_req(1, 1, 1, 16'h0001);
    queue_req(-1, 0, 1, 16'h5555);
    for (int i = 0; i < 8; i++) queue_req(3, -4, 12, pts[i]);
    queue_req(16'sh8000, 16'sh7fff, 1, 16'haaaa);
    queue_req(1, 0, 0, 16'h0000);
    for (int i = 0; i < 800; i++)
      queue_req(rand_axis(), rand_axis(), rand_axis(),
                $urandom_range(0, 3) == 0 ? pts[$urandom_range(0, 7)] : 16'($urandom));
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        gap_left = 0;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          if (!quiet_tail && pending_reqs.size() < 100) quiet_tail = 1'b1;
          if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 13) - 1;
            start <= 1'b0;
          end else begin
            rot_req_t q;
            q = pending_reqs.pop_front();
            axis_x <= q.ax;
            axis_y <= q.ay;
            axis_z <= q.az;
            turn_phase <= q.ph;
            start <= 1'b1;
            expected_mats.insert(expected_mats.size(), rodrigues_matrix(q));
          end
        end else begin
          start <= 1'b0;
          driving_done = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        logic [15:0] got[9];
        rot_mat_t e;
        got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
        if (expected_mats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected matrix at %0t", $realtime);
        end else begin
          e = expected_mats.pop_front();
          matrices_seen++;
          if (e.za) zero_axis_seen++;
          for (int i = 0; i < 9; i++) begin
            if (got[i] !== e.m[i]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("matrix %0d r%0d%0d: expected %0d got %0d", matrices_seen, i / 3,
                         i % 3, $signed(e.m[i]), $signed(got[i]));
            end
          end
          if (zero_axis !== e.za) begin
            mismatches++;
            if (mismatches <= 10)
              $display("matrix %0d zero_axis: expected %0b got %0b", matrices_seen, e.za,
                       zero_axis);
          end
        end
      end
    end
  end

  initial begin
    wait (driving_done && expected_mats.size() == 0);
    repeat (LAT_TOTAL + 10) @(posedge clk);
    $display("Checked %0d rotation matrices, %0d with a zero axis.", matrices_seen,
             zero_axis_seen);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Timeout after %0d idle cycles", idle_cycles);
    $display("Some tests failed");
    $finish;
  end
endmodule
